// File: rtl/assert_macros.svh
// Assertion helpers; the enclosing module provides clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FNWC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define FNWC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define FNWC_ASSERT(lbl, prop, msg)
`define FNWC_NEVER(lbl, cond, msg)
`endif
`endif

// File: rtl/fnwc_pkg.sv
`default_nettype none
package fnwc_pkg;

  localparam int REF_W     = 26;
  localparam int TWOREF_W  = 27;
  localparam int CARRIER_W = 31;
  localparam int DEV_W     = 20;
  localparam int NUM_W     = 25;
  localparam int ODIV_W    = 5;
  localparam int PFD_W     = 26;
  localparam int FRAC_W    = 19;
  localparam int DIV_QW    = CARRIER_W + FRAC_W;
  localparam int DEV_PAD_W = DIV_QW - NUM_W - FRAC_W;
  localparam int DEVW_W    = 24;

  localparam logic [REF_W-1:0]     REF_RESET_HZ = 26'd25600000;
  localparam logic [CARRIER_W-1:0] LIMIT_BAND5  = 31'd177000000;
  localparam logic [CARRIER_W-1:0] LIMIT_BAND4  = 31'd239000000;
  localparam logic [CARRIER_W-1:0] LIMIT_BAND3  = 31'd353000000;
  localparam logic [CARRIER_W-1:0] LIMIT_BAND2  = 31'd525000000;
  localparam logic [CARRIER_W-1:0] LIMIT_BAND1  = 31'd705000000;

  localparam logic [27:0] DIV3_MUL   = 28'd178956971;
  localparam int          DIV3_SHIFT = 29;

  localparam logic [2:0] BAND_5 = 3'd5;
  localparam logic [2:0] BAND_4 = 3'd4;
  localparam logic [2:0] BAND_3 = 3'd3;
  localparam logic [2:0] BAND_2 = 3'd2;
  localparam logic [2:0] BAND_1 = 3'd1;
  localparam logic [2:0] BAND_0 = 3'd0;

  localparam logic [7:0]        INTDIV_MAX = 8'hFF;
  localparam logic [FRAC_W:0]   FRAC_MAX   = 20'hFFFFF;
  localparam logic [DEVW_W-1:0] DEVW_MAX   = 24'hFFFFFF;

  typedef struct packed {
    logic [2:0]           band;
    logic [CARRIER_W-1:0] carrier;
    logic [PFD_W-1:0]     pfd;
    logic [TWOREF_W-1:0]  tworef;
    logic [NUM_W-1:0]     num;
  } entry_t;

  typedef struct packed {
    logic [2:0] band;
    logic       pfd_zero;
    logic       ref_zero;
  } side_t;

endpackage
`default_nettype wire

// File: rtl/fnwc_if.sv
`default_nettype none
interface fnwc_in_if;
  logic        valid;
  logic        ready;
  logic [30:0] carrier_hz;
  logic [19:0] fsk_dev_hz;
  modport source (output valid, carrier_hz, fsk_dev_hz, input ready);
  modport sink (input valid, carrier_hz, fsk_dev_hz, output ready);
endinterface

interface fnwc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  band_code;
  logic [7:0]  integer_divider;
  logic [19:0] fraction_word;
  logic [23:0] deviation_word;
  logic        out_of_range;
  modport source (output valid, band_code, integer_divider, fraction_word, deviation_word,
                  out_of_range, input ready);
  modport sink (input valid, band_code, integer_divider, fraction_word, deviation_word,
                out_of_range, output ready);
endinterface
`default_nettype wire

// File: rtl/fnwc_front.sv
`default_nettype none
module fnwc_front import fnwc_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [REF_W-1:0] ref_i,
  fnwc_in_if.sink               req_i,
  input  wire logic             full_i,
  output logic                  push_o,
  output entry_t                entry_o
);

  logic                 vld_q;
  logic [CARRIER_W-1:0] carrier_q;
  logic [DEV_W-1:0]     dev_q;

  logic [2:0]           band;
  logic [ODIV_W-1:0]    odiv;
  logic                 tri_f;
  logic [2:0]           shamt;
  logic [TWOREF_W-1:0]  tworef;
  logic [TWOREF_W-1:0]  x;
  logic [54:0]          prod;

  assign req_i.ready = !vld_q || !full_i;
  assign push_o      = vld_q && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (req_i.ready) begin
      vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      carrier_q <= req_i.carrier_hz;
      dev_q     <= req_i.fsk_dev_hz;
    end
  end

  always_comb begin
    if (carrier_q < LIMIT_BAND5) begin
      band = BAND_5; odiv = 5'd24; tri_f = 1'b1; shamt = 3'd3;
    end else if (carrier_q < LIMIT_BAND4) begin
      band = BAND_4; odiv = 5'd16; tri_f = 1'b0; shamt = 3'd4;
    end else if (carrier_q < LIMIT_BAND3) begin
      band = BAND_3; odiv = 5'd12; tri_f = 1'b1; shamt = 3'd2;
    end else if (carrier_q < LIMIT_BAND2) begin
      band = BAND_2; odiv = 5'd8;  tri_f = 1'b0; shamt = 3'd3;
    end else if (carrier_q < LIMIT_BAND1) begin
      band = BAND_1; odiv = 5'd6;  tri_f = 1'b1; shamt = 3'd1;
    end else begin
      band = BAND_0; odiv = 5'd4;  tri_f = 1'b0; shamt = 3'd2;
    end
  end

  assign tworef = {ref_i, 1'b0};
  assign x      = tworef >> shamt;
  assign prod   = 55'(x) * 55'(DIV3_MUL);

  always_comb begin
    entry_o.band    = band;
    entry_o.carrier = carrier_q;
    entry_o.pfd     = tri_f ? prod[DIV3_SHIFT +: PFD_W] : x[PFD_W-1:0];
    entry_o.tworef  = tworef;
    entry_o.num     = NUM_W'(dev_q) * NUM_W'(odiv);
  end

endmodule
`default_nettype wire

// File: rtl/fnwc_fifo.sv
`default_nettype none
`include "assert_macros.svh"
module fnwc_fifo import fnwc_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire entry_t data_i,
  input  wire logic   pop_i,
  output entry_t      data_o,
  output logic        full_o,
  output logic        empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = AW + 1;

  entry_t         mem_q [DEPTH];
  logic [AW-1:0]  wr_ptr_q;
  logic [AW-1:0]  rd_ptr_q;
  logic [CW-1:0]  cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CW'(DEPTH));
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `FNWC_ASSERT(a_cnt_bound, cnt_q <= CW'(DEPTH), "queue count beyond depth")
  `FNWC_ASSERT(a_empty_ptrs, (cnt_q == '0) |-> (rd_ptr_q == wr_ptr_q), "empty queue with ptr skew")
  `FNWC_ASSERT(a_cnt_up, (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + 1'b1), "count not advanced")

endmodule
`default_nettype wire

// File: rtl/fnwc_divpipe.sv
`default_nettype none
module fnwc_divpipe #(
  parameter int QW = 50,
  parameter int DW = 26
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [QW-1:0] dividend_i,
  input  wire logic [DW-1:0] divisor_i,
  output logic      [QW-1:0] quotient_o
);

  logic [DW-1:0] rem_q  [QW];
  logic [QW-1:0] work_q [QW];
  logic [DW-1:0] dsr_q  [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stg
    logic [DW-1:0] rem_s;
    logic [DW-1:0] dsr_s;
    logic [QW-1:0] work_s;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    if (i == 0) begin : g_first
      assign rem_s  = '0;
      assign work_s = dividend_i;
      assign dsr_s  = divisor_i;
    end else begin : g_next
      assign rem_s  = rem_q[i-1];
      assign work_s = work_q[i-1];
      assign dsr_s  = dsr_q[i-1];
    end

    assign trial = {rem_s, work_s[QW-1]};
    assign diff  = trial - {1'b0, dsr_s};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= diff[DW] ? trial[DW-1:0] : diff[DW-1:0];
        work_q[i] <= {work_s[QW-2:0], ~diff[DW]};
        dsr_q[i]  <= dsr_s;
      end
    end
  end

  assign quotient_o = work_q[QW-1];

endmodule
`default_nettype wire

// File: rtl/fnwc_back.sv
`default_nettype none
module fnwc_back import fnwc_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire entry_t entry_i,
  input  wire logic   empty_i,
  output logic        pop_o,
  fnwc_out_if.source  rsp_o
);

  logic              en;
  logic [DIV_QW-1:0] vld_q;
  side_t             side_q [DIV_QW];
  side_t             side_in;
  logic [DIV_QW-1:0] quo_c;
  logic [DIV_QW-1:0] quo_d;

  logic                 out_vld_q;
  logic [2:0]           band_q;
  logic [7:0]           intdiv_q;
  logic [FRAC_W:0]      frac_q;
  logic [DEVW_W-1:0]    devw_q;
  logic                 oor_q;

  logic [CARRIER_W-1:0] qc;
  logic [7:0]           intdiv_d;
  logic [FRAC_W:0]      frac_d;
  logic [DEVW_W-1:0]    devw_d;
  logic                 oor_d;
  side_t                side_last;

  assign en    = !out_vld_q || rsp_o.ready;
  assign pop_o = en && !empty_i;

  assign side_in.band     = entry_i.band;
  assign side_in.pfd_zero = (entry_i.pfd == '0);
  assign side_in.ref_zero = (entry_i.tworef == '0);

  fnwc_divpipe #(.QW(DIV_QW), .DW(PFD_W)) u_div_carrier (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i ({entry_i.carrier, {FRAC_W{1'b0}}}),
    .divisor_i  (entry_i.pfd),
    .quotient_o (quo_c)
  );

  fnwc_divpipe #(.QW(DIV_QW), .DW(TWOREF_W)) u_div_dev (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i ({{DEV_PAD_W{1'b0}}, entry_i.num, {FRAC_W{1'b0}}}),
    .divisor_i  (entry_i.tworef),
    .quotient_o (quo_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[DIV_QW-2:0], pop_o};
      out_vld_q <= vld_q[DIV_QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_in;
      for (int i = 1; i < DIV_QW; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  assign side_last = side_q[DIV_QW-1];
  assign qc        = quo_c[DIV_QW-1:FRAC_W];

  always_comb begin
    oor_d = 1'b0;
    if (side_last.pfd_zero) begin
      intdiv_d = INTDIV_MAX;
      frac_d   = FRAC_MAX;
      oor_d    = 1'b1;
    end else begin
      frac_d = {1'b1, quo_c[FRAC_W-1:0]};
      if (qc == '0) begin
        intdiv_d = '0;
        oor_d    = 1'b1;
      end else if (qc > CARRIER_W'(256)) begin
        intdiv_d = INTDIV_MAX;
        oor_d    = 1'b1;
      end else begin
        intdiv_d = 8'(qc - 1'b1);
      end
    end
    if (side_last.ref_zero || (|quo_d[DIV_QW-1:DEVW_W])) begin
      devw_d = DEVW_MAX;
      oor_d  = 1'b1;
    end else begin
      devw_d = quo_d[DEVW_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      band_q   <= side_last.band;
      intdiv_q <= intdiv_d;
      frac_q   <= frac_d;
      devw_q   <= devw_d;
      oor_q    <= oor_d;
    end
  end

  assign rsp_o.valid           = out_vld_q;
  assign rsp_o.band_code       = band_q;
  assign rsp_o.integer_divider = intdiv_q;
  assign rsp_o.fraction_word   = frac_q;
  assign rsp_o.deviation_word  = devw_q;
  assign rsp_o.out_of_range    = oor_q;

endmodule
`default_nettype wire

// File: rtl/fracn_synth_word_calc_unit.sv
`default_nettype none
// Fractional-N frequency word calculator. Each request (carrier and FSK
// deviation in hertz) yields one result: band code, integer divider, 20-bit
// fraction word, 24-bit deviation word and an out-of-range flag. The
// reference frequency register is written through cfg_we_i/cfg_wdata_i and
// resets to 25.6 MHz. One request is taken per cycle while the queue is not
// full; a request passes through the input register, the queue, 50 divider
// stages producing one quotient bit each, and the output register. The two
// divider pipelines are 50-stage restoring dividers.
module fracn_synth_word_calc_unit import fnwc_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [REF_W-1:0] cfg_wdata_i,
  fnwc_in_if.sink               req_i,
  fnwc_out_if.source            rsp_o
);

  logic [REF_W-1:0] ref_q;
  logic             push;
  logic             pop;
  logic             full;
  logic             empty;
  entry_t           entry_wr;
  entry_t           entry_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q <= REF_RESET_HZ;
    end else if (cfg_we_i) begin
      ref_q <= cfg_wdata_i;
    end
  end

  fnwc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ref_i   (ref_q),
    .req_i   (req_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (entry_wr)
  );

  fnwc_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (entry_wr),
    .pop_i   (pop),
    .data_o  (entry_rd),
    .full_o  (full),
    .empty_o (empty)
  );

  fnwc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .entry_i (entry_rd),
    .empty_i (empty),
    .pop_o   (pop),
    .rsp_o   (rsp_o)
  );

endmodule
`default_nettype wire

// File: verif/fracn_synth_word_calc_unit_chk.sv
`timescale 1ns / 1ps
module fracn_synth_word_calc_unit_chk import fnwc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [REF_W-1:0] cfg_wdata_i,
  fnwc_in_if               req,
  fnwc_out_if              rsp,
  output int               pending_o,
  output int               errors_o
);

  typedef struct packed {
    logic [2:0]        band;
    logic [7:0]        intdiv;
    logic [FRAC_W:0]   frac;
    logic [DEVW_W-1:0] devw;
    logic              oor;
  } word_set_t;

  logic [REF_W-1:0] ref_hz;
  word_set_t        words_q[$];

  function automatic word_set_t calc_words(input logic [CARRIER_W-1:0] carrier,
                                           input logic [DEV_W-1:0] dev,
                                           input logic [REF_W-1:0] rf);
    word_set_t w;
    longint unsigned odiv, pfd, quo, rem, dw;
    w.oor = 1'b0;
    if (carrier < LIMIT_BAND5) begin
      odiv = 24; w.band = BAND_5;
    end else if (carrier < LIMIT_BAND4) begin
      odiv = 16; w.band = BAND_4;
    end else if (carrier < LIMIT_BAND3) begin
      odiv = 12; w.band = BAND_3;
    end else if (carrier < LIMIT_BAND2) begin
      odiv = 8; w.band = BAND_2;
    end else if (carrier < LIMIT_BAND1) begin
      odiv = 6; w.band = BAND_1;
    end else begin
      odiv = 4; w.band = BAND_0;
    end
    pfd = (2 * longint'(rf)) / odiv;
    if (pfd == 0) begin
      w.intdiv = INTDIV_MAX;
      w.frac   = FRAC_MAX;
      w.oor    = 1'b1;
    end else begin
      quo = longint'(carrier) / pfd;
      rem = longint'(carrier) % pfd;
      if (quo == 0) begin
        w.intdiv = 8'd0;
        w.oor    = 1'b1;
      end else if (quo - 1 > 255) begin
        w.intdiv = INTDIV_MAX;
        w.oor    = 1'b1;
      end else begin
        w.intdiv = 8'(quo - 1);
      end
      w.frac = 20'(64'd524288 + (rem * 64'd524288) / pfd);
    end
    if (rf == 0) begin
      w.devw = DEVW_MAX;
      w.oor  = 1'b1;
    end else begin
      dw = (64'd524288 * odiv * longint'(dev)) / (2 * longint'(rf));
      if (dw > 64'hFFFFFF) begin
        w.devw = DEVW_MAX;
        w.oor  = 1'b1;
      end else begin
        w.devw = 24'(dw);
      end
    end
    return w;
  endfunction

  assign pending_o = words_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    word_set_t w;
    if (!rst_ni) begin
      ref_hz   <= REF_RESET_HZ;
      errors_o <= 0;
      words_q.delete();
    end else begin
      if (cfg_we_i) ref_hz <= cfg_wdata_i;
      if (req.valid && req.ready)
        words_q.push_back(calc_words(req.carrier_hz, req.fsk_dev_hz, ref_hz));
      if (rsp.valid && rsp.ready) begin
        if (words_q.size() == 0) begin
          $display("%0t: result with nothing outstanding", $realtime);
          errors_o <= errors_o + 1;
        end else begin
          w = words_q.pop_front();
          if (rsp.band_code !== w.band || rsp.integer_divider !== w.intdiv ||
              rsp.fraction_word !== w.frac || rsp.deviation_word !== w.devw ||
              rsp.out_of_range !== w.oor) begin
            $display("%0t: mismatch expected band %0d div %0d frac %h dev %h oor %b",
                     $realtime, w.band, w.intdiv, w.frac, w.devw, w.oor);
            $display("%0t:          actual   band %0d div %0d frac %h dev %h oor %b",
                     $realtime, rsp.band_code, rsp.integer_divider, rsp.fraction_word,
                     rsp.deviation_word, rsp.out_of_range);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

endmodule

// File: verif/fracn_synth_word_calc_unit_tb.sv
`timescale 1ns / 1ps
module fracn_synth_word_calc_unit_tb import fnwc_pkg::*; ();

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [REF_W-1:0] cfg_wdata_i;
  int               pending;
  int               errors;
  int               burst_left;
  int unsigned      cyc;

  fnwc_in_if  req();
  fnwc_out_if rsp();

  fracn_synth_word_calc_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req),
    .rsp_o      (rsp)
  );

  fracn_synth_word_calc_unit_chk u_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req        (req),
    .rsp        (rsp),
    .pending_o  (pending),
    .errors_o   (errors)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    case ((cyc >> 9) % 3)
      0: begin
        rsp.ready <= 1'b1;
      end
      1: begin
        rsp.ready <= ($urandom_range(9, 0) < 7);
      end
      default: begin
        rsp.ready <= ((cyc % 7) < 3);
      end
    endcase
  end

  task automatic send_freq(input logic [CARRIER_W-1:0] carrier,
                           input logic [DEV_W-1:0] dev);
    req.valid      <= 1'b1;
    req.carrier_hz <= carrier;
    req.fsk_dev_hz <= dev;
    do @(posedge clk_i); while (!req.ready);
    if (burst_left == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
      burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(80, 20) : $urandom_range(8, 0);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain_wait();
    req.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_ref(input logic [REF_W-1:0] val);
    drain_wait();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [CARRIER_W-1:0] rand_carrier();
    logic [CARRIER_W-1:0] edges[5];
    edges = '{LIMIT_BAND5, LIMIT_BAND4, LIMIT_BAND3, LIMIT_BAND2, LIMIT_BAND1};
    case ($urandom_range(3, 0))
      0, 1: return CARRIER_W'($urandom_range(1100000000, 0));
      2:    return CARRIER_W'($urandom);
      default: return CARRIER_W'(edges[$urandom_range(4, 0)] + $urandom_range(40, 0) - 20);
    endcase
  endfunction

  function automatic logic [DEV_W-1:0] rand_dev();
    if ($urandom_range(1, 0)) return DEV_W'($urandom_range(1000000, 0));
    return DEV_W'($urandom);
  endfunction

  initial begin
    logic [CARRIER_W-1:0] dir_carrier[16];
    logic [REF_W-1:0]     refs[9];
    dir_carrier = '{31'd0, 31'd1000, 31'd176999999, 31'd177000000, 31'd238999999,
                    31'd239000000, 31'd352999999, 31'd353000000, 31'd524999999,
                    31'd525000000, 31'd704999999, 31'd705000000, 31'd433920000,
                    31'd1100000000, 31'h7FFFFFFF, 31'h55555555};
    refs = '{26'd1000000, 26'd50000000, 26'h3FFFFFF, 26'd0, 26'd1, 26'd11,
             26'd300000, 26'd25600000, 26'd1000000};
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    req.valid      = 1'b0;
    req.carrier_hz = '0;
    req.fsk_dev_hz = '0;
    rsp.ready      = 1'b0;
    cyc            = 0;
    burst_left     = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_carrier[i])
      send_freq(dir_carrier[i], (i % 3 == 0) ? 20'd0 : (i % 3 == 1) ? 20'hFFFFF : 20'd1000000);

    for (int p = 0; p < 9; p++) begin
      write_ref((p == 8) ? REF_W'($urandom_range(50000000, 1000000)) : refs[p]);
      send_freq(31'h7FFFFFFF, 20'hFFFFF);
      send_freq(31'd0, 20'd0);
      for (int n = 0; n < 215; n++) begin
        if (p == 1 && n == 100) drain_wait();
        send_freq(rand_carrier(), rand_dev());
      end
    end

    drain_wait();
    if (errors == 0 && pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

endmodule
